// ===== hw/rtl/mrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Modem response deframer package
// Shared constants, result kinds, the command record and the prefix tables.
// ----------------------------------------------------------------------------
package mrd_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int NUM_W        = 7;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEN_W        = 16;

  localparam logic [6:0] MAXP_RESET = 7'd64;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] RCV_TAG_LEN = 16'd8;
  localparam logic [15:0] CLS_TAG_LEN = 16'd11;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_NOTICE  = 2'd2,
    KIND_CLOSED  = 2'd3
  } kind_t;

  typedef struct packed {
    logic             drain;
    kind_t            kind;
    logic [NUM_W-1:0] num;
    logic [LEN_W-1:0] length;
    logic             trunc;
  } cmd_t;

  function automatic logic [7:0] rcv_tag(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h43;
      3'd2:    ch = 8'h49;
      3'd3:    ch = 8'h50;
      3'd4:    ch = 8'h52;
      3'd5:    ch = 8'h43;
      3'd6:    ch = 8'h56;
      default: ch = 8'h3A;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] cls_tag(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h2B;
      4'd1:    ch = 8'h54;
      4'd2:    ch = 8'h43;
      4'd3:    ch = 8'h50;
      4'd4:    ch = 8'h43;
      4'd5:    ch = 8'h4C;
      4'd6:    ch = 8'h4F;
      4'd7:    ch = 8'h53;
      4'd8:    ch = 8'h45;
      4'd9:    ch = 8'h44;
      4'd10:   ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/modem_response_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// Modem response deframer
// Splits received modem bytes into text lines and framed payloads, reports
// oversize payloads and server close events.
// ----------------------------------------------------------------------------
//   Channel  | Direction | Handshake          | Beat contents
//   in_      | input     | in_valid/in_stall  | one received byte
//   out_     | output    | out_valid/out_stall| kind, byte, length, truncated, last
//   cfg_     | input     | cfg_valid/cfg_ready| max_payload limit
//
// A byte that ends no message posts no command and raises no stall of its own.
// A line or payload drains at one beat per cycle while out_stall is low;
// input is stalled until the last byte of that drain reaches the result register.
// Notices and events pass through a two-entry command queue; input stalls only
// while that queue is full.
// Reset is synchronous; no buffer clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module modem_response_deframer_unit #(
  parameter int BUFFER_DEPTH = mrd_pkg::BUFFER_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_rx_byte,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [6:0]                cfg_max_payload,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_data_byte,
  output logic [mrd_pkg::LEN_W-1:0] out_msg_length,
  output logic                      out_truncated,
  output logic                      out_last
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              q_push, q_full, q_pop, q_empty, drain_done;
  mrd_pkg::cmd_t     push_cmd, pop_cmd;

  mrd_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_payload (cfg_max_payload),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .q_push          (q_push),
    .q_cmd           (push_cmd),
    .q_full          (q_full),
    .drain_done      (drain_done)
  );

  mrd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  mrd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .q_cmd          (pop_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .drain_done     (drain_done),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_msg_length (out_msg_length),
    .out_truncated  (out_truncated),
    .out_last       (out_last)
  );

endmodule

// ===== hw/rtl/mrd_front.sv =====
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts received bytes, tracks the line, length and payload phases, writes
// the message buffer and posts commands for the drain engine.
// ----------------------------------------------------------------------------
module mrd_front #(
  parameter int BUFFER_DEPTH = mrd_pkg::BUFFER_DEPTH,
  localparam int ADDR_W = $clog2(BUFFER_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_max_payload,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [7:0]         wr_data,
  output logic               q_push,
  output mrd_pkg::cmd_t      q_cmd,
  input  logic               q_full,
  input  logic               drain_done
);

  localparam logic [15:0] DEPTH16 = 16'(BUFFER_DEPTH);

  typedef enum logic [2:0] {
    PH_LINE = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    PS_SKIP = 3'b001,
    PS_NUM  = 3'b010,
    PS_DONE = 3'b100
  } parse_t;

  phase_t      phase_r, phase_nxt;
  parse_t      ps_r, ps_nxt, ps_upd;
  logic [15:0] count_r, count_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] acc_r, acc_nxt, acc_upd, len_val;
  logic [1:0]  pm_r, pm_nxt, pm_upd;
  logic [6:0]  maxp_r;
  logic        pend_r, pend_nxt;

  logic        accept, in_buf, keep, is_ws, is_digit, is_sign, rcv_mis, cls_mis;
  logic [15:0] cnt_inc, limit16, pos;
  logic [19:0] acc_x;
  logic [7:0]  b;

  assign cfg_ready = 1'b1;
  assign in_stall  = pend_r || q_full;

  always_comb begin
    b        = in_rx_byte;
    accept   = in_valid && !in_stall;
    pos      = count_r;
    cnt_inc  = (count_r == 16'hFFFF) ? count_r : count_r + 16'd1;
    limit16  = ({9'd0, maxp_r} < DEPTH16) ? {9'd0, maxp_r} : DEPTH16;
    keep     = plen_r <= limit16;
    in_buf   = pos < DEPTH16;
    is_ws    = (b == mrd_pkg::CH_SPACE) || ((b >= mrd_pkg::CH_TAB) && (b <= mrd_pkg::CH_CR));
    is_digit = (b >= mrd_pkg::CH_ZERO) && (b <= mrd_pkg::CH_NINE);
    is_sign  = (b == mrd_pkg::CH_PLUS) || (b == mrd_pkg::CH_MINUS);
    rcv_mis  = (pos < mrd_pkg::RCV_TAG_LEN) && (b != mrd_pkg::rcv_tag(pos[2:0]));
    cls_mis  = (pos < mrd_pkg::CLS_TAG_LEN) && (b != mrd_pkg::cls_tag(pos[3:0]));
    pm_upd   = pm_r & ~{cls_mis, rcv_mis};

    acc_x = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {16'd0, b[3:0]};
    ps_upd  = ps_r;
    acc_upd = acc_r;
    unique case (ps_r)
      PS_SKIP: begin
        if (is_digit) begin
          ps_upd  = PS_NUM;
          acc_upd = {12'd0, b[3:0]};
        end else if (is_sign) begin
          ps_upd = PS_NUM;
        end else if (!is_ws) begin
          ps_upd = PS_DONE;
        end
      end
      PS_NUM: begin
        if (is_digit) begin
          acc_upd = (acc_x > 20'h0FFFF) ? 16'hFFFF : acc_x[15:0];
        end else begin
          ps_upd = PS_DONE;
        end
      end
      default: ;
    endcase
    len_val = in_buf ? acc_upd : acc_r;

    phase_nxt = phase_r;
    ps_nxt    = ps_r;
    count_nxt = count_r;
    plen_nxt  = plen_r;
    acc_nxt   = acc_r;
    pm_nxt    = pm_r;
    wr_en     = 1'b0;
    wr_addr   = pos[ADDR_W-1:0];
    wr_data   = b;
    q_push    = 1'b0;
    q_cmd     = '0;

    if (accept) begin
      unique case (phase_r)
        PH_LINE: begin
          wr_en = in_buf;
          if (b == mrd_pkg::CH_LF) begin
            q_push       = 1'b1;
            q_cmd.drain  = 1'b1;
            q_cmd.kind   = mrd_pkg::KIND_LINE;
            q_cmd.length = cnt_inc;
            q_cmd.trunc  = cnt_inc > DEPTH16;
            q_cmd.num    = (cnt_inc > DEPTH16) ? DEPTH16[mrd_pkg::NUM_W-1:0]
                                               : cnt_inc[mrd_pkg::NUM_W-1:0];
            phase_nxt    = PH_LINE;
            count_nxt    = '0;
            pm_nxt       = 2'b11;
          end else if ((cnt_inc == mrd_pkg::RCV_TAG_LEN) && pm_upd[0]) begin
            phase_nxt = PH_LEN;
            count_nxt = '0;
            pm_nxt    = 2'b11;
            ps_nxt    = PS_SKIP;
            acc_nxt   = '0;
          end else if ((cnt_inc == mrd_pkg::CLS_TAG_LEN) && pm_upd[1]) begin
            q_push     = 1'b1;
            q_cmd.kind = mrd_pkg::KIND_CLOSED;
            phase_nxt  = PH_LINE;
            count_nxt  = '0;
            pm_nxt     = 2'b11;
          end else begin
            count_nxt = cnt_inc;
            pm_nxt    = pm_upd;
          end
        end
        PH_LEN: begin
          wr_en     = in_buf;
          count_nxt = cnt_inc;
          if (in_buf) begin
            ps_nxt  = ps_upd;
            acc_nxt = acc_upd;
          end
          if (b == mrd_pkg::CH_COMMA) begin
            plen_nxt  = len_val;
            count_nxt = '0;
            if (len_val == 16'd0) begin
              q_push     = 1'b1;
              q_cmd.kind = mrd_pkg::KIND_PAYLOAD;
              phase_nxt  = PH_LINE;
              pm_nxt     = 2'b11;
            end else begin
              if (len_val > limit16) begin
                q_push       = 1'b1;
                q_cmd.kind   = mrd_pkg::KIND_NOTICE;
                q_cmd.length = len_val;
              end
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          wr_en     = in_buf && keep;
          count_nxt = cnt_inc;
          if (cnt_inc >= plen_r) begin
            if (keep) begin
              q_push       = 1'b1;
              q_cmd.drain  = 1'b1;
              q_cmd.kind   = mrd_pkg::KIND_PAYLOAD;
              q_cmd.length = plen_r;
              q_cmd.num    = plen_r[mrd_pkg::NUM_W-1:0];
            end
            phase_nxt = PH_LINE;
            count_nxt = '0;
            pm_nxt    = 2'b11;
          end
        end
        default: ;
      endcase
    end

    pend_nxt = (pend_r && !drain_done) || (q_push && q_cmd.drain);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE;
      ps_r    <= PS_SKIP;
      count_r <= '0;
      plen_r  <= '0;
      acc_r   <= '0;
      pm_r    <= 2'b11;
      maxp_r  <= mrd_pkg::MAXP_RESET;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ps_r    <= ps_nxt;
      count_r <= count_nxt;
      plen_r  <= plen_nxt;
      acc_r   <= acc_nxt;
      pm_r    <= pm_nxt;
      pend_r  <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        maxp_r <= cfg_max_payload;
      end
    end
  end

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> plen_r != 16'd0)
    else $error("payload phase entered with zero length");

endmodule

// ===== hw/rtl/mrd_queue.sv =====
// ----------------------------------------------------------------------------
// Deframer command queue
// Short first-in first-out queue of commands between front end and drain engine.
// ----------------------------------------------------------------------------
module mrd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mrd_pkg::cmd_t pop_cmd,
  output logic          empty
);

  mrd_pkg::cmd_t               slot_r [mrd_pkg::QUEUE_DEPTH];
  logic [mrd_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [mrd_pkg::QPTR_W:0]    fill_r, fill_nxt;

  assign full    = fill_r == (mrd_pkg::QPTR_W + 1)'(mrd_pkg::QUEUE_DEPTH);
  assign empty   = fill_r == '0;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue underflow");

endmodule

// ===== hw/rtl/mrd_back.sv =====
// ----------------------------------------------------------------------------
// Deframer drain engine
// Holds the message buffer, executes queued commands and drives the result
// register, one drained byte per beat.
// ----------------------------------------------------------------------------
module mrd_back #(
  parameter int BUFFER_DEPTH = mrd_pkg::BUFFER_DEPTH,
  localparam int ADDR_W = $clog2(BUFFER_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [7:0]                wr_data,
  input  mrd_pkg::cmd_t             q_cmd,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      drain_done,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_data_byte,
  output logic [mrd_pkg::LEN_W-1:0] out_msg_length,
  output logic                      out_truncated,
  output logic                      out_last
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  logic [7:0]          mem [BUFFER_DEPTH];
  logic [7:0]          rd_data_r;
  state_t              st_r, st_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  mrd_pkg::cmd_t       cmd_r, cmd_nxt;

  logic                      out_valid_r, out_valid_nxt;
  mrd_pkg::kind_t            out_kind_r, ld_kind;
  logic [7:0]                out_data_r, ld_data;
  logic [mrd_pkg::LEN_W-1:0] out_len_r, ld_len;
  logic                      out_trunc_r, ld_trunc;
  logic                      out_last_r, ld_last;
  logic                      can_load, load, is_last;

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_byte  = out_data_r;
  assign out_msg_length = out_len_r;
  assign out_truncated  = out_trunc_r;
  assign out_last       = out_last_r;

  always_comb begin
    can_load   = !out_valid_r || !out_stall;
    is_last    = (mrd_pkg::NUM_W'(idx_r) + mrd_pkg::NUM_W'(1)) == cmd_r.num;
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    q_pop      = 1'b0;
    drain_done = 1'b0;
    load       = 1'b0;
    ld_kind    = cmd_r.kind;
    ld_data    = 8'd0;
    ld_len     = cmd_r.length;
    ld_trunc   = 1'b0;
    ld_last    = 1'b1;
    unique case (st_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (!q_empty && can_load) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.drain) begin
            st_nxt = S_DRAIN;
          end else begin
            load    = 1'b1;
            ld_kind = q_cmd.kind;
            ld_len  = q_cmd.length;
          end
        end
      end
      S_DRAIN: begin
        if (can_load) begin
          load     = 1'b1;
          ld_data  = rd_data_r;
          ld_trunc = cmd_r.trunc;
          ld_last  = is_last;
          if (is_last) begin
            st_nxt     = S_IDLE;
            idx_nxt    = '0;
            drain_done = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (load) begin
      out_kind_r  <= ld_kind;
      out_data_r  <= ld_data;
      out_len_r   <= ld_len;
      out_trunc_r <= ld_trunc;
      out_last_r  <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DRAIN |-> mrd_pkg::NUM_W'(idx_r) < cmd_r.num)
    else $error("drain index beyond message length");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == mrd_pkg::KIND_NOTICE || out_kind_r == mrd_pkg::KIND_CLOSED)
      |-> out_last_r && (out_data_r == 8'd0))
    else $error("notice or event beat is malformed");

endmodule
